FILE: sv/fsp_pkg.sv
// fsp_pkg: types, codes and reset values shared by the format specification parser.
// No dependencies; used by every other file of the block.
`default_nettype none

package fsp_pkg;

	localparam int unsigned CharW = 8;
	localparam int unsigned ValW  = 32;

	localparam logic [ValW-1:0] SatMax = {1'b0, {(ValW-1){1'b1}}};

	typedef enum logic [2:0] {
		PH_FLAGS       = 3'd0,
		PH_WIDTH       = 3'd1,
		PH_AFTER_WIDTH = 3'd2,
		PH_PREC        = 3'd3,
		PH_LEN         = 3'd4,
		PH_LEN_H       = 3'd5,
		PH_LEN_L       = 3'd6,
		PH_LEN_DONE    = 3'd7
	} phase_t;

	localparam logic [1:0] PAD_NONE  = 2'd0;
	localparam logic [1:0] PAD_ZERO  = 2'd1;
	localparam logic [1:0] PAD_LEFT  = 2'd2;

	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_SPACE = 2'd1;
	localparam logic [1:0] SIGN_PLUS  = 2'd2;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_HH   = 3'd1;
	localparam logic [2:0] LEN_H    = 3'd2;
	localparam logic [2:0] LEN_L    = 3'd3;
	localparam logic [2:0] LEN_LL   = 3'd4;
	localparam logic [2:0] LEN_BIGL = 3'd5;

	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
	localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_HASH  = 8'h23;
	localparam logic [CharW-1:0] CH_STAR  = 8'h2a;
	localparam logic [CharW-1:0] CH_DOT   = 8'h2e;
	localparam logic [CharW-1:0] CH_LOW_H = 8'h68;
	localparam logic [CharW-1:0] CH_LOW_L = 8'h6c;
	localparam logic [CharW-1:0] CH_BIG_L = 8'h4c;

	typedef struct packed {
		phase_t          phase;
		logic [1:0]      pad;
		logic [1:0]      sign;
		logic            alt;
		logic [ValW-1:0] width;
		logic [ValW-1:0] prec;
		logic [2:0]      len;
	} fsp_state_t;

	localparam fsp_state_t StateRst = '{
		phase: PH_FLAGS,
		pad:   PAD_NONE,
		sign:  SIGN_NONE,
		alt:   1'b0,
		width: '0,
		prec:  '1,
		len:   LEN_NONE
	};

endpackage

`default_nettype wire

FILE: sv/format_spec_parser.sv
// format_spec_parser: top level; input word register, parse state and result register.
// Depends on fsp_pkg and fsp_step.
//
// Takes the bytes after a percent sign one word per cycle and returns one result word
// when the specifier byte arrives, carrying every parsed field. A word is registered
// on entry and resolved from that register against the parse state, and the result
// is then registered in the result register; one word is accepted every cycle for as
// long as the result register is free or being drained. in_stall rises only while a
// finished result waits under out_stall and the word held on entry is a specifier.
`default_nettype none

module format_spec_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [fsp_pkg::CharW-1:0]    char_code,
	input  wire logic signed [fsp_pkg::ValW-1:0] star_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [fsp_pkg::CharW-1:0]         spec_char,
	output logic [1:0]                        pad_mode,
	output logic [1:0]                        sign_mode,
	output logic                              alt_form,
	output logic signed [fsp_pkg::ValW-1:0]   field_width,
	output logic signed [fsp_pkg::ValW-1:0]   prec_value,
	output logic [2:0]                        length_code
);

	logic                        valid_s1;
	logic [fsp_pkg::CharW-1:0]   char_s1;
	logic [fsp_pkg::ValW-1:0]    star_s1;
	fsp_pkg::fsp_state_t         state_q;
	fsp_pkg::fsp_state_t         state_nxt;
	logic                        emit;
	logic                        adv_s1;
	logic                        out_valid_q;
	logic [fsp_pkg::CharW-1:0]   spec_q;
	logic [1:0]                  pad_q;
	logic [1:0]                  sign_q;
	logic                        alt_q;
	logic [fsp_pkg::ValW-1:0]    width_q;
	logic [fsp_pkg::ValW-1:0]    prec_q;
	logic [2:0]                  len_q;

	fsp_step u_step (
		.cur        (state_q),
		.char_code  (char_s1),
		.star_value (star_s1),
		.nxt        (state_nxt),
		.emit       (emit)
	);

	assign adv_s1   = !emit || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_code;
			star_s1 <= star_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsp_pkg::StateRst;
		end else if (valid_s1 && adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && emit && adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && emit && adv_s1) begin
			spec_q  <= char_s1;
			pad_q   <= state_q.pad;
			sign_q  <= state_q.sign;
			alt_q   <= state_q.alt;
			width_q <= state_q.width;
			prec_q  <= state_q.prec;
			len_q   <= state_q.len;
		end
	end

	assign out_valid   = out_valid_q;
	assign spec_char   = spec_q;
	assign pad_mode    = pad_q;
	assign sign_mode   = sign_q;
	assign alt_form    = alt_q;
	assign field_width = width_q;
	assign prec_value  = prec_q;
	assign length_code = len_q;

endmodule

`default_nettype wire

FILE: sv/fsp_digit_acc.sv
// fsp_digit_acc: decimal digit accumulate (acc * 10 + d), saturating at the signed maximum.
// Depends on fsp_pkg.
`default_nettype none

module fsp_digit_acc (
	input  wire logic [fsp_pkg::ValW-2:0]  acc,
	input  wire logic [fsp_pkg::CharW-1:0] char_code,
	output logic      [fsp_pkg::ValW-1:0]  result
);

	localparam int unsigned ProdW = fsp_pkg::ValW + 3;

	logic [ProdW-1:0]         prod;
	logic [fsp_pkg::CharW-1:0] digit;

	assign digit = char_code - fsp_pkg::CH_ZERO;

	always_comb begin
		prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
			+ {{(ProdW-4){1'b0}}, digit[3:0]};
		if (prod[ProdW-1:fsp_pkg::ValW-1] != '0) begin
			result = fsp_pkg::SatMax;
		end else begin
			result = prod[fsp_pkg::ValW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: sv/fsp_step.sv
// fsp_step: one parse step; resolves phase fall-through for a word and gives next state.
// Depends on fsp_pkg and fsp_digit_acc.
`default_nettype none

module fsp_step (
	input  wire fsp_pkg::fsp_state_t         cur,
	input  wire logic [fsp_pkg::CharW-1:0]   char_code,
	input  wire logic [fsp_pkg::ValW-1:0]    star_value,
	output fsp_pkg::fsp_state_t              nxt,
	output logic                             emit
);

	logic                      is_digit;
	logic                      is_star;
	logic                      to_width;
	logic                      to_prec;
	logic [fsp_pkg::ValW-2:0]  acc_sel;
	logic [fsp_pkg::ValW-1:0]  acc_new;
	fsp_pkg::phase_t           ph;

	assign ph       = cur.phase;
	assign is_digit = (char_code >= fsp_pkg::CH_ZERO) && (char_code <= fsp_pkg::CH_NINE);
	assign is_star  = (char_code == fsp_pkg::CH_STAR);
	assign to_width = (ph == fsp_pkg::PH_FLAGS) || (ph == fsp_pkg::PH_WIDTH);
	assign to_prec  = (ph == fsp_pkg::PH_PREC);
	assign acc_sel  = to_prec ? cur.prec[fsp_pkg::ValW-2:0] : cur.width[fsp_pkg::ValW-2:0];

	fsp_digit_acc u_digit (
		.acc       (acc_sel),
		.char_code (char_code),
		.result    (acc_new)
	);

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		if (ph == fsp_pkg::PH_FLAGS && char_code == fsp_pkg::CH_MINUS) begin
			nxt.pad = fsp_pkg::PAD_LEFT;
		end else if (ph == fsp_pkg::PH_FLAGS && char_code == fsp_pkg::CH_ZERO) begin
			if (cur.pad != fsp_pkg::PAD_LEFT) begin
				nxt.pad = fsp_pkg::PAD_ZERO;
			end
		end else if (ph == fsp_pkg::PH_FLAGS && char_code == fsp_pkg::CH_PLUS) begin
			nxt.sign = fsp_pkg::SIGN_PLUS;
		end else if (ph == fsp_pkg::PH_FLAGS && char_code == fsp_pkg::CH_SPACE) begin
			if (cur.sign != fsp_pkg::SIGN_PLUS) begin
				nxt.sign = fsp_pkg::SIGN_SPACE;
			end
		end else if (ph == fsp_pkg::PH_FLAGS && char_code == fsp_pkg::CH_HASH) begin
			nxt.alt = 1'b1;
		end else if (to_width && is_digit) begin
			nxt.width = acc_new;
			nxt.phase = fsp_pkg::PH_WIDTH;
		end else if (to_width && is_star) begin
			nxt.width = star_value;
			nxt.phase = fsp_pkg::PH_AFTER_WIDTH;
		end else if ((to_width || ph == fsp_pkg::PH_AFTER_WIDTH)
				&& char_code == fsp_pkg::CH_DOT) begin
			nxt.prec  = '0;
			nxt.phase = fsp_pkg::PH_PREC;
		end else if (to_prec && is_digit) begin
			nxt.prec = acc_new;
		end else if (to_prec && is_star) begin
			nxt.prec  = star_value;
			nxt.phase = fsp_pkg::PH_LEN;
		end else if ((to_width || ph == fsp_pkg::PH_AFTER_WIDTH || to_prec
				|| ph == fsp_pkg::PH_LEN) && char_code == fsp_pkg::CH_LOW_H) begin
			nxt.len   = fsp_pkg::LEN_H;
			nxt.phase = fsp_pkg::PH_LEN_H;
		end else if ((to_width || ph == fsp_pkg::PH_AFTER_WIDTH || to_prec
				|| ph == fsp_pkg::PH_LEN) && char_code == fsp_pkg::CH_LOW_L) begin
			nxt.len   = fsp_pkg::LEN_L;
			nxt.phase = fsp_pkg::PH_LEN_L;
		end else if ((to_width || ph == fsp_pkg::PH_AFTER_WIDTH || to_prec
				|| ph == fsp_pkg::PH_LEN) && char_code == fsp_pkg::CH_BIG_L) begin
			nxt.len   = fsp_pkg::LEN_BIGL;
			nxt.phase = fsp_pkg::PH_LEN_DONE;
		end else if (ph == fsp_pkg::PH_LEN_H && char_code == fsp_pkg::CH_LOW_H) begin
			nxt.len   = fsp_pkg::LEN_HH;
			nxt.phase = fsp_pkg::PH_LEN_DONE;
		end else if (ph == fsp_pkg::PH_LEN_L && char_code == fsp_pkg::CH_LOW_L) begin
			nxt.len   = fsp_pkg::LEN_LL;
			nxt.phase = fsp_pkg::PH_LEN_DONE;
		end else begin
			// specifier: result comes from cur, parser returns to reset state
			nxt  = fsp_pkg::StateRst;
			emit = 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: sv/fsp_checker.sv
// fsp_checker: port-level assertions for format_spec_parser, bound to the top level.
// Depends on fsp_pkg and format_spec_parser.
`default_nettype none

module fsp_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [fsp_pkg::CharW-1:0]    spec_char,
	input wire logic [1:0]                   pad_mode,
	input wire logic [1:0]                   sign_mode,
	input wire logic [2:0]                   length_code
);

	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("in_stall without a held result");

	a_modes_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pad_mode != 2'd3) && (sign_mode != 2'd3)
			&& (length_code != 3'd6) && (length_code != 3'd7))
		else $error("illegal mode code in result");

	a_held_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(spec_char)
			&& $stable(pad_mode) && $stable(length_code))
		else $error("held result changed");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("activity straight out of reset");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.spec_char   (spec_char),
	.pad_mode    (pad_mode),
	.sign_mode   (sign_mode),
	.length_code (length_code)
);

`default_nettype wire
